// ===== hw/rtl/bfd_pkg.sv =====
// shared types, constants and register codes of the box filter downscaler
package bfd_pkg;

   localparam int PIX_W       = 8;
   localparam int HSUM_W      = 10;
   localparam int CSUM_W      = 12;
   localparam int FACTOR_W    = 3;
   localparam int WIDTH_W     = 12;
   localparam int HEIGHT_W    = 13;
   localparam int ROW_W       = 12;
   localparam int SUB_W       = 2;
   localparam int NUM_CH      = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int QUEUE_DEPTH = 4;

   localparam int DEFAULT_MAX_OUT_WIDTH = 2048;
   localparam int MAX_OUT_HEIGHT        = 4096;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_HEIGHT   = 2'd2;

   // factor codes
   localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 3'd1;
   localparam logic [FACTOR_W-1:0] FACTOR_TWO   = 3'd2;
   localparam logic [FACTOR_W-1:0] FACTOR_THREE = 3'd3;
   localparam logic [FACTOR_W-1:0] FACTOR_FOUR  = 3'd4;

   // divide by nine as multiply by ceil(2^15/9) then shift, exact below 2^15
   localparam logic [CSUM_W-1:0] RECIP_NINE  = 12'd3641;
   localparam int                RECIP_SHIFT = 15;

   // one block column of one pixel row, handed from front to back
   typedef struct packed {
      logic [NUM_CH-1:0][HSUM_W-1:0] hsum;
      logic                          first_row;
      logic                          emit;
      logic [FACTOR_W-1:0]           factor;
      logic                          row_end;
      logic                          frame_end;
   } job_type;

   typedef logic [NUM_CH-1:0][CSUM_W-1:0] csum_type;

endpackage

// ===== hw/rtl/bfd_if.sv =====
// request and response channel interfaces of the box filter downscaler
interface bfd_req_if;
   import bfd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] in_red;
   logic [PIX_W-1:0] in_green;
   logic [PIX_W-1:0] in_blue;
   modport source (output valid, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink (input valid, input in_red, input in_green, input in_blue,
                 output ready);
endinterface

interface bfd_rsp_if;
   import bfd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;
   logic             row_end;
   logic             frame_end;
   modport source (output valid, output out_red, output out_green, output out_blue,
                   output row_end, output frame_end, input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 input row_end, input frame_end, output ready);
endinterface

// ===== hw/rtl/bfd_front.sv =====
// front end: config registers, block position counters and horizontal sums
module bfd_front #(
   parameter int MAX_OUT_WIDTH = bfd_pkg::DEFAULT_MAX_OUT_WIDTH,
   parameter int COL_W         = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [bfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bfd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   bfd_req_if.sink                          req_chan,
   output logic                             push_valid,
   output bfd_pkg::job_type                 push_job,
   output logic [COL_W-1:0]                 push_idx,
   input  logic                             push_ready
);
   import bfd_pkg::*;

   localparam int EW    = $clog2(MAX_OUT_WIDTH + 1);
   localparam int CMP_W = ((EW > WIDTH_W) ? EW : WIDTH_W) + 1;

   logic [FACTOR_W-1:0] scale_ff, scale_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [SUB_W-1:0]    sub_col_ff, sub_col_in;
   logic [SUB_W-1:0]    sub_row_ff, sub_row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [NUM_CH-1:0][HSUM_W-1:0] hp_ff, hp_in;

   logic [FACTOR_W-1:0] eff_f;
   logic [CMP_W-1:0]    eff_w;
   logic [HEIGHT_W-1:0] eff_h;
   logic [NUM_CH-1:0][HSUM_W-1:0] hs;
   logic [NUM_CH-1:0][PIX_W-1:0]  px;
   logic accept, col_end, row_done, last_col, last_row, cfg_hit;

   assign px[0] = req_chan.in_red;
   assign px[1] = req_chan.in_green;
   assign px[2] = req_chan.in_blue;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid & push_ready;

   // clamp register values to their legal ranges
   always_comb begin
      case (scale_ff) inside
         3'd0:         eff_f = FACTOR_ONE;
         [3'd1:3'd4]:  eff_f = scale_ff;
         default:      eff_f = FACTOR_FOUR;
      endcase
      if (width_ff == '0) begin
         eff_w = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_OUT_WIDTH)) begin
         eff_w = CMP_W'(MAX_OUT_WIDTH);
      end else begin
         eff_w = CMP_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_W'(MAX_OUT_HEIGHT)) begin
         eff_h = HEIGHT_W'(MAX_OUT_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         hs[c] = ((sub_col_ff == '0) ? HSUM_W'(0) : hp_ff[c]) + HSUM_W'(px[c]);
      end
   end

   assign col_end  = ({1'b0, sub_col_ff} + 3'd1) >= eff_f;
   assign row_done = ({1'b0, sub_row_ff} + 3'd1) >= eff_f;
   assign last_col = (CMP_W'(col_ff) + CMP_W'(1)) >= eff_w;
   assign last_row = ({1'b0, row_ff} + HEIGHT_W'(1)) >= eff_h;

   assign push_valid         = accept & col_end;
   assign push_idx           = col_ff;
   assign push_job.hsum      = hs;
   assign push_job.first_row = (sub_row_ff == '0);
   assign push_job.emit      = row_done;
   assign push_job.factor    = eff_f;
   assign push_job.row_end   = last_col;
   assign push_job.frame_end = last_col & last_row;

   always_comb begin
      scale_in   = scale_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      sub_col_in = sub_col_ff;
      sub_row_in = sub_row_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      hp_in      = hp_ff;
      cfg_hit    = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            REG_SCALE_FACTOR: begin
               scale_in = csr_wdata[FACTOR_W-1:0];
               cfg_hit  = 1'b1;
            end
            REG_OUT_WIDTH: begin
               width_in = csr_wdata[WIDTH_W-1:0];
               cfg_hit  = 1'b1;
            end
            REG_OUT_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_W-1:0];
               cfg_hit   = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end
      if (cfg_hit) begin
         // any register write restarts the frame
         sub_col_in = '0;
         sub_row_in = '0;
         col_in     = '0;
         row_in     = '0;
         hp_in      = '0;
      end else if (accept) begin
         if (!col_end) begin
            hp_in      = hs;
            sub_col_in = sub_col_ff + SUB_W'(1);
         end else begin
            hp_in      = '0;
            sub_col_in = '0;
            if (last_col) begin
               col_in = '0;
               if (row_done) begin
                  sub_row_in = '0;
                  row_in     = last_row ? '0 : row_ff + ROW_W'(1);
               end else begin
                  sub_row_in = sub_row_ff + SUB_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= FACTOR_ONE;
         width_ff   <= WIDTH_W'(1);
         height_ff  <= HEIGHT_W'(1);
         sub_col_ff <= '0;
         sub_row_ff <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         hp_ff      <= '0;
      end else begin
         scale_ff   <= scale_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         sub_col_ff <= sub_col_in;
         sub_row_ff <= sub_row_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         hp_ff      <= hp_in;
      end
   end

endmodule

// ===== hw/rtl/bfd_fifo.sv =====
// small first-in first-out queue between front and back
module bfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bfd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/bfd_back.sv =====
// back end: column sum store update, averaging and output register
module bfd_back #(
   parameter int MAX_OUT_WIDTH = bfd_pkg::DEFAULT_MAX_OUT_WIDTH,
   parameter int COL_W         = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  bfd_pkg::job_type  pop_job,
   input  logic [COL_W-1:0]  pop_idx,
   output logic              pop_ready,
   bfd_rsp_if.source         rsp_chan
);
   import bfd_pkg::*;

   csum_type col_mem_ff [MAX_OUT_WIDTH];
   csum_type rdata_ff;
   csum_type fwd_data_ff;
   logic     fwd_hit_ff;

   logic             b_valid_ff, b_valid_in;
   job_type          b_job_ff;
   logic [COL_W-1:0] b_idx_ff;

   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_red_ff, out_green_ff, out_blue_ff;
   logic             out_row_end_ff, out_frame_end_ff;

   csum_type prev_sum, cs;
   logic push_ok, b_done, advance, pop, mem_we, out_load;

   function automatic logic [PIX_W-1:0] box_average(input logic [CSUM_W-1:0] sum,
                                                    input logic [FACTOR_W-1:0] factor);
      logic [2*CSUM_W-1:0] prod;
      logic [CSUM_W-1:0]   scaled;
      prod = (2*CSUM_W)'(sum) * (2*CSUM_W)'(RECIP_NINE);
      case (factor)
         FACTOR_TWO:   scaled = sum >> 2;
         FACTOR_THREE: scaled = CSUM_W'(prod >> RECIP_SHIFT);
         FACTOR_FOUR:  scaled = sum >> 4;
         default:      scaled = sum;
      endcase
      return scaled[PIX_W-1:0];
   endfunction

   assign push_ok   = !out_valid_ff | rsp_chan.ready;
   assign b_done    = b_valid_ff & (!b_job_ff.emit | push_ok);
   assign advance   = !b_valid_ff | b_done;
   assign pop_ready = advance;
   assign pop       = pop_valid & advance;
   assign mem_we    = b_valid_ff & !b_job_ff.emit;
   assign out_load  = b_done & b_job_ff.emit;

   // a write issued in the same cycle as the read is forwarded
   always_comb begin
      if (b_job_ff.first_row) begin
         prev_sum = '0;
      end else if (fwd_hit_ff) begin
         prev_sum = fwd_data_ff;
      end else begin
         prev_sum = rdata_ff;
      end
      for (int c = 0; c < NUM_CH; c++) begin
         cs[c] = prev_sum[c] + CSUM_W'(b_job_ff.hsum[c]);
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (advance) begin
         b_valid_in = pop_valid;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_job_ff    <= pop_job;
         b_idx_ff    <= pop_idx;
         fwd_hit_ff  <= mem_we & (b_idx_ff == pop_idx);
         fwd_data_ff <= cs;
      end
      if (out_load) begin
         out_red_ff       <= box_average(cs[0], b_job_ff.factor);
         out_green_ff     <= box_average(cs[1], b_job_ff.factor);
         out_blue_ff      <= box_average(cs[2], b_job_ff.factor);
         out_row_end_ff   <= b_job_ff.row_end;
         out_frame_end_ff <= b_job_ff.frame_end;
      end
   end

   // column sum store: one write and one read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         col_mem_ff[b_idx_ff] <= cs;
      end
      if (pop) begin
         rdata_ff <= col_mem_ff[pop_idx];
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_red   = out_red_ff;
   assign rsp_chan.out_green = out_green_ff;
   assign rsp_chan.out_blue  = out_blue_ff;
   assign rsp_chan.row_end   = out_row_end_ff;
   assign rsp_chan.frame_end = out_frame_end_ff;

endmodule

// ===== hw/rtl/box_filter_downscaler.sv =====
// top level of the integer-factor box filter image downscaler
// usage
//   req_chan carries rgb pixels of the oversampled image in raster order, one
//   request per pixel; the input row is scale_factor * out_width pixels wide
//   rsp_chan carries one averaged pixel per scale_factor x scale_factor block,
//   with row_end on the last pixel of an output row and frame_end on the last
//   pixel of the frame
//   csr port: write the three registers while idle; any write restarts the frame
// timing
//   one request per cycle sustained; the front takes a pixel each cycle while
//   the four-entry queue has room
//   a block-completing pixel reaches rsp_chan through the queue, the column
//   store read and then the output register; the back end retires one queued
//   column per cycle unless rsp_chan stalls, with one store read and write
// reset and stall
//   reset returns registers to factor 1, width 1, height 1 and empties the
//   queue; the column store needs no clearing since each entry is written on the
//   first row of a band before it is read
//   a stalled rsp_chan holds its output register; the back end and then the
//   queue fill, and req_chan.ready drops only once the queue is full
module box_filter_downscaler #(
   parameter int MAX_OUT_WIDTH = bfd_pkg::DEFAULT_MAX_OUT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [bfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   bfd_req_if.sink                         req_chan,
   bfd_rsp_if.source                       rsp_chan
);
   import bfd_pkg::*;

   // column index into the sum store
   localparam int COL_W  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int JOB_W  = $bits(job_type);
   localparam int FIFO_W = JOB_W + COL_W;

   // front to queue
   logic              push_valid;
   job_type           push_job;
   logic [COL_W-1:0]  push_idx;
   logic              push_ready;
   logic [FIFO_W-1:0] push_data;

   // queue to back
   logic              pop_valid;
   logic [FIFO_W-1:0] pop_data;
   logic              pop_ready;
   job_type           pop_job;
   logic [COL_W-1:0]  pop_idx;

   assign push_data = {push_idx, push_job};
   assign pop_job   = job_type'(pop_data[JOB_W-1:0]);
   assign pop_idx   = pop_data[FIFO_W-1:JOB_W];

   // counters and horizontal sums; emits one entry per block column of each pixel row
   bfd_front #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .COL_W         (COL_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .push_valid   (push_valid),
      .push_job     (push_job),
      .push_idx     (push_idx),
      .push_ready   (push_ready)
   );

   // decouples the pixel stream from output stalls
   bfd_fifo #(
      .WIDTH (FIFO_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // column store read-modify-write and averaging
   bfd_back #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .COL_W         (COL_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_idx   (pop_idx),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== hw/rtl/bfd_checker.sv =====
// port-level checks of the box filter downscaler and their bind
module bfd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [bfd_pkg::PIX_W-1:0] rsp_red,
   input logic [bfd_pkg::PIX_W-1:0] rsp_green,
   input logic [bfd_pkg::PIX_W-1:0] rsp_blue,
   input logic                      rsp_row_end,
   input logic                      rsp_frame_end
);
   import bfd_pkg::*;

   // reset empties the output register
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // reset empties the queue so requests are taken at once
   a_reset_opens_req: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready after reset");

   // the last pixel of a frame is also the last of its row
   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_red, rsp_green, rsp_blue, rsp_row_end, rsp_frame_end}))
      else $error("stalled response changed");

endmodule

bind box_filter_downscaler bfd_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_red       (rsp_chan.out_red),
   .rsp_green     (rsp_chan.out_green),
   .rsp_blue      (rsp_chan.out_blue),
   .rsp_row_end   (rsp_chan.row_end),
   .rsp_frame_end (rsp_chan.frame_end)
);
